### sv/u2u_pkg.sv
// u2u_pkg: shared constants and types for the utf-8 to utf-16 transcoder
// used by the front, queue and back modules and the top level
package u2u_pkg;

	localparam logic [15:0] REPL_UNIT   = 16'hFFFD;
	localparam logic [20:0] MAX_CP      = 21'h10FFFF;
	localparam logic [20:0] SURR_LO     = 21'h00D800;
	localparam logic [20:0] SURR_HI     = 21'h00DFFF;
	localparam logic [20:0] SUPP_BASE   = 21'h010000;
	localparam logic [15:0] HI_SURR     = 16'hD800;
	localparam logic [15:0] LO_SURR     = 16'hDC00;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// work for the back end produced by one accepted byte
	typedef struct packed {
		logic [2:0]  n_repl;
		logic [1:0]  n_units;
		logic [15:0] unit0;
		logic [15:0] unit1;
		logic        eot;
	} burst_t;

endpackage

### sv/u2u_in_if.sv
// u2u_in_if: byte channel of the transcoder, valid/ready with byte and end mark
// no dependencies
interface u2u_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_text;

	modport source (output valid, output in_byte, output end_of_text, input ready);
	modport sink (input valid, input in_byte, input end_of_text, output ready);
endinterface

### sv/u2u_out_if.sv
// u2u_out_if: code unit channel of the transcoder, valid/ready with utf-16 unit
// no dependencies
interface u2u_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] code_unit;
	logic        is_replacement;
	logic        last_unit;

	modport source (output valid, output code_unit, output is_replacement,
		output last_unit, input ready);
	modport sink (input valid, input code_unit, input is_replacement,
		input last_unit, output ready);
endinterface

### sv/u2u_front.sv
// u2u_front: accepts bytes, tracks the open sequence and classifies each byte
// into a burst of code units; depends on u2u_pkg and u2u_in_if
module u2u_front
	import u2u_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	u2u_in_if.sink        byte_ch,
	input  logic          full,
	output logic          push,
	output burst_t        push_data
);

	logic [1:0]  pend_q;
	logic [2:0]  len_q;
	logic [20:0] cp_q;

	logic [1:0]  pend_d;
	logic [2:0]  len_d;
	logic [20:0] cp_d;

	logic [7:0]  b;
	logic        eot;
	logic        accept;
	logic        is_cont;
	logic [2:0]  lead_len;
	logic [20:0] lead_bits;
	logic [2:0]  held;
	logic [20:0] cp_next;
	logic [20:0] cp_off;
	logic        over;
	logic        bad;
	burst_t      bst;

	assign b       = byte_ch.in_byte;
	assign eot     = byte_ch.end_of_text;
	assign byte_ch.ready = !full;
	assign accept  = byte_ch.valid && !full;
	assign is_cont = (b[7:6] == 2'b10);
	assign held    = {1'b0, pend_q} + 3'd1;
	assign cp_next = {cp_q[14:0], b[5:0]};
	assign cp_off  = cp_next - SUPP_BASE;

	always_comb begin
		lead_len  = 3'd0;
		lead_bits = '0;
		if (b[7:5] == 3'b110) begin
			lead_len  = 3'd2;
			lead_bits = {16'd0, b[4:0]};
		end else if (b[7:4] == 4'b1110) begin
			lead_len  = 3'd3;
			lead_bits = {17'd0, b[3:0]};
		end else if (b[7:3] == 5'b11110) begin
			lead_len  = 3'd4;
			lead_bits = {18'd0, b[2:0]};
		end
	end

	always_comb begin
		over = ((len_q == 3'd2) && (cp_next < 21'h80))
			|| ((len_q == 3'd3) && (cp_next < 21'h800))
			|| ((len_q == 3'd4) && (cp_next < SUPP_BASE));
		bad  = (cp_next > MAX_CP) || ((cp_next >= SURR_LO) && (cp_next <= SURR_HI));
	end

	always_comb begin
		bst        = '0;
		bst.eot    = eot;
		pend_d     = pend_q;
		len_d      = len_q;
		cp_d       = cp_q;
		if ((pend_q != 2'd0) && is_cont) begin
			if (held >= len_q) begin
				pend_d = '0;
				len_d  = '0;
				cp_d   = '0;
				if (over || bad) begin
					bst.n_repl = held;
				end else if (cp_next <= 21'h00FFFF) begin
					bst.n_units = 2'd1;
					bst.unit0   = cp_next[15:0];
				end else begin
					bst.n_units = 2'd2;
					bst.unit0   = HI_SURR + {6'd0, cp_off[19:10]};
					bst.unit1   = LO_SURR + {6'd0, cp_off[9:0]};
				end
			end else if (eot) begin
				bst.n_repl = held;
				pend_d     = '0;
				len_d      = '0;
				cp_d       = '0;
			end else begin
				pend_d = held[1:0];
				cp_d   = cp_next;
			end
		end else begin
			// no open sequence, or one cut short by a non-continuation byte; then the byte itself as ascii or a new lead
			bst.n_repl = {1'b0, pend_q};
			pend_d     = '0;
			len_d      = '0;
			cp_d       = '0;
			if (!b[7]) begin
				bst.n_units = 2'd1;
				bst.unit0   = {8'd0, b};
			end else if ((lead_len == 3'd0) || eot) begin
				bst.n_repl = bst.n_repl + 3'd1;
			end else begin
				pend_d = 2'd1;
				len_d  = lead_len;
				cp_d   = lead_bits;
			end
		end
	end

	assign push_data = bst;
	assign push      = accept && ((bst.n_repl != 3'd0) || (bst.n_units != 2'd0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			len_q  <= '0;
			cp_q   <= '0;
		end else if (accept) begin
			pend_q <= pend_d;
			len_q  <= len_d;
			cp_q   <= cp_d;
		end
	end

endmodule

### sv/u2u_queue.sv
// u2u_queue: short first-in first-out queue of bursts between front and back
// depends on u2u_pkg
module u2u_queue
	import u2u_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  burst_t push_data,
	input  logic   pop,
	output burst_t head,
	output logic   full,
	output logic   empty
);

	burst_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	assign full  = (count_q == QCNT_W'(QDEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push) else $error("burst pushed into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !pop) else $error("burst popped from empty queue");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QDEPTH)) else $error("queue count out of range");
`endif

endmodule

### sv/u2u_back.sv
// u2u_back: walks each burst and sends one utf-16 code unit per cycle while the
// receiver keeps up, through an output register; depends on u2u_pkg and u2u_out_if
module u2u_back
	import u2u_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  burst_t    head,
	input  logic      empty,
	output logic      pop,
	u2u_out_if.source unit_ch
);

	logic        valid_q;
	logic [15:0] code_q;
	logic        repl_q;
	logic        last_q;
	logic [2:0]  idx_q;

	logic        out_load;
	logic [2:0]  total;
	logic        at_end;
	logic [2:0]  unit_idx;
	logic [15:0] code_d;
	logic        repl_d;

	assign total    = head.n_repl + {1'b0, head.n_units};
	assign at_end   = (idx_q == total - 3'd1);
	assign out_load = !valid_q || unit_ch.ready;
	assign pop      = out_load && !empty && at_end;
	assign unit_idx = idx_q - head.n_repl;

	always_comb begin
		if (idx_q < head.n_repl) begin
			code_d = REPL_UNIT;
			repl_d = 1'b1;
		end else begin
			code_d = (unit_idx == 3'd0) ? head.unit0 : head.unit1;
			repl_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (out_load) begin
			valid_q <= !empty;
			if (!empty) begin
				idx_q <= at_end ? 3'd0 : idx_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load && !empty) begin
			code_q <= code_d;
			repl_q <= repl_d;
			last_q <= head.eot && at_end;
		end
	end

	assign unit_ch.valid          = valid_q;
	assign unit_ch.code_unit      = code_q;
	assign unit_ch.is_replacement = repl_q;
	assign unit_ch.last_unit      = last_q;

`ifndef SYNTH
	a_idx_idle: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> idx_q == 3'd0) else $error("unit index left over with no burst");
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> idx_q < total) else $error("unit index beyond burst");
	a_repl_code: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && repl_q |-> code_q == REPL_UNIT) else $error("replacement flag on other unit");
	a_pop_rewind: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> idx_q == 3'd0) else $error("index not rewound after burst");
`endif

endmodule

### sv/utf8_to_utf16_transcoder_core.sv
// utf8_to_utf16_transcoder_core: top level of the utf-8 to utf-16 transcoder
// depends on u2u_pkg, u2u_in_if, u2u_out_if, u2u_front, u2u_queue, u2u_back
//
// byte_ch takes one utf-8 byte per item with end_of_text set on the final byte
// of a text; unit_ch gives one utf-16 code unit per item, surrogate halves high
// first, is_replacement on each U+FFFD for malformed input and last_unit on the
// final unit of a text.
// the front takes a byte every cycle while the burst queue has room and updates
// the open sequence in that cycle; each byte turns into zero to four units.
// a unit passes through the burst queue, written at the accepting edge, and the
// output register before it appears on unit_ch. while the receiver keeps up the
// back sends one unit per cycle, so the sustained rate is one byte per cycle
// while each byte gives at most one unit; bytes giving two to four units hold
// the back while it sends each of them, and the four-entry queue absorbs them
// before byte_ch.ready falls.
// reset empties the open sequence, the queue and the output register.
// when the receiver holds unit_ch.ready low the output register holds its unit,
// the queue fills and then byte_ch.ready drops; nothing is lost or repeated.
module utf8_to_utf16_transcoder_core
	import u2u_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	u2u_in_if.sink    byte_ch,
	u2u_out_if.source unit_ch
);

	logic   push;
	logic   pop;
	logic   full;
	logic   empty;
	burst_t push_data;
	burst_t head;

	u2u_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_ch   (byte_ch),
		.full      (full),
		.push      (push),
		.push_data (push_data)
	);

	u2u_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.full      (full),
		.empty     (empty)
	);

	u2u_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.empty   (empty),
		.pop     (pop),
		.unit_ch (unit_ch)
	);

endmodule

### test/utf16_unit_checker.sv
`timescale 1ns / 100ps
// utf16_unit_checker: watches both channels of the transcoder, predicts the utf-16 units
// of every accepted byte and compares them in order with the units the core gives
// depends on u2u_pkg, u2u_in_if and u2u_out_if
module utf16_unit_checker
	import u2u_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	u2u_in_if    byte_ch,
	u2u_out_if   unit_ch,
	output int   mismatch_count,
	output int   units_due_count
);

	typedef struct packed {
		logic [15:0] code_unit;
		logic        is_replacement;
		logic        last_unit;
	} utf16_unit_t;

	logic [1:0]  seq_held = '0;
	logic [2:0]  seq_len = '0;
	logic [20:0] seq_bits = '0;
	utf16_unit_t units_due[$];
	utf16_unit_t step_units[$];

	initial begin
		mismatch_count = 0;
		units_due_count = 0;
	end

	task automatic report_mismatch(input string msg);
		$display("%0t ns: %s", $time, msg);
		mismatch_count++;
	endtask

	function automatic void emit_unit(input logic [15:0] code, input logic repl);
		utf16_unit_t u;
		u.code_unit = code;
		u.is_replacement = repl;
		u.last_unit = 1'b0;
		step_units = {step_units, u};
	endfunction

	function automatic void emit_replacements(input int n);
		for (int i = 0; i < n; i++)
			emit_unit(REPL_UNIT, 1'b1);
	endfunction

	function automatic void emit_code_point(input logic [20:0] cp);
		logic [20:0] offset;
		if (cp <= 21'h00FFFF) begin
			emit_unit(cp[15:0], 1'b0);
		end else begin
			offset = cp - SUPP_BASE;
			emit_unit(HI_SURR + {6'd0, offset[19:10]}, 1'b0);
			emit_unit(LO_SURR + {6'd0, offset[9:0]}, 1'b0);
		end
	endfunction

	function automatic void clear_sequence();
		seq_held = '0;
		seq_len = '0;
		seq_bits = '0;
	endfunction

	function automatic void open_sequence(input logic [7:0] b, input logic eot);
		logic [2:0]  len;
		logic [20:0] bits;
		len = 3'd0;
		bits = '0;
		if (!b[7]) begin
			emit_unit({8'd0, b}, 1'b0);
		end else begin
			if (b[7:5] == 3'b110) begin
				len = 3'd2;
				bits = {16'd0, b[4:0]};
			end else if (b[7:4] == 4'b1110) begin
				len = 3'd3;
				bits = {17'd0, b[3:0]};
			end else if (b[7:3] == 5'b11110) begin
				len = 3'd4;
				bits = {18'd0, b[2:0]};
			end
			if (len == 3'd0 || eot) begin
				emit_replacements(1);
			end else begin
				seq_held = 2'd1;
				seq_len = len;
				seq_bits = bits;
			end
		end
	endfunction

	function automatic void transcode_byte(input logic [7:0] b, input logic eot);
		logic [2:0]  held;
		logic [20:0] cp;
		logic        overlong;
		logic        out_of_range;
		step_units.delete();
		if (seq_held != 2'd0) begin
			if (b[7:6] == 2'b10) begin
				held = {1'b0, seq_held} + 3'd1;
				cp = {seq_bits[14:0], b[5:0]};
				if (held >= seq_len) begin
					overlong = (seq_len == 3'd2 && cp < 21'h80) ||
						(seq_len == 3'd3 && cp < 21'h800) ||
						(seq_len == 3'd4 && cp < SUPP_BASE);
					out_of_range = cp > MAX_CP || (cp >= SURR_LO && cp <= SURR_HI);
					if (overlong || out_of_range)
						emit_replacements(held);
					else
						emit_code_point(cp);
					clear_sequence();
				end else if (eot) begin
					emit_replacements(held);
					clear_sequence();
				end else begin
					seq_held = held[1:0];
					seq_bits = cp;
				end
			end else begin
				// broken sequence: one replacement per held byte, then a fresh lead
				emit_replacements(seq_held);
				clear_sequence();
				open_sequence(b, eot);
			end
		end else begin
			open_sequence(b, eot);
		end
		if (eot && step_units.size() > 0)
			step_units[step_units.size() - 1].last_unit = 1'b1;
		foreach (step_units[i])
			units_due = {units_due, step_units[i]};
	endfunction

	always @(posedge clk or negedge arst_n) begin
		utf16_unit_t got;
		utf16_unit_t want;
		if (!arst_n) begin
			clear_sequence();
			units_due.delete();
			units_due_count <= 0;
		end else begin
			if (byte_ch.valid && byte_ch.ready)
				transcode_byte(byte_ch.in_byte, byte_ch.end_of_text);
			if (unit_ch.valid && unit_ch.ready) begin
				got = {unit_ch.code_unit, unit_ch.is_replacement, unit_ch.last_unit};
				if (units_due.size() == 0) begin
					report_mismatch($sformatf("unit %h with none due", got.code_unit));
				end else begin
					want = units_due.pop_front();
					if (got.code_unit !== want.code_unit)
						report_mismatch($sformatf("code_unit %h, due %h",
							got.code_unit, want.code_unit));
					if (got.is_replacement !== want.is_replacement)
						report_mismatch($sformatf("is_replacement %b, due %b on unit %h",
							got.is_replacement, want.is_replacement, want.code_unit));
					if (got.last_unit !== want.last_unit)
						report_mismatch($sformatf("last_unit %b, due %b on unit %h",
							got.last_unit, want.last_unit, want.code_unit));
				end
			end
			units_due_count <= units_due.size();
		end
	end

endmodule

### test/utf8_to_utf16_transcoder_core_test.sv
`timescale 1ns / 100ps
// utf8_to_utf16_transcoder_core_test: feeds directed and random utf-8 text into the
// transcoder with random idling on both channels and gives the verdict
// depends on u2u_pkg, u2u_in_if, u2u_out_if, the transcoder core and utf16_unit_checker
module utf8_to_utf16_transcoder_core_test
	import u2u_pkg::*;
();

	logic clk;
	logic arst_n;
	int   sender_idle_pct = 24;
	int   sink_stall_pct = 63;
	int   bytes_sent = 0;
	int   mismatch_count;
	int   units_due_count;

	// {end_of_text, byte}: ascii extremes, shortest and longest valid forms,
	// stray continuation, invalid lead, broken sequence, overlong, surrogate,
	// beyond U+10FFFF and a sequence cut short by the end of text
	logic [8:0] directed_bytes[$] = '{
		9'h000, 9'h17F, 9'h0C2, 9'h080, 9'h0EF, 9'h0BF, 9'h0BF,
		9'h0F4, 9'h08F, 9'h0BF, 9'h0BF, 9'h080, 9'h0FF, 9'h0E2, 9'h041,
		9'h0C1, 9'h0BF, 9'h0ED, 9'h0A0, 9'h080,
		9'h0F4, 9'h090, 9'h080, 9'h080, 9'h0F0, 9'h19F
	};

	u2u_in_if  byte_ch();
	u2u_out_if unit_ch();

	utf8_to_utf16_transcoder_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.byte_ch(byte_ch),
		.unit_ch(unit_ch)
	);

	utf16_unit_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.byte_ch        (byte_ch),
		.unit_ch        (unit_ch),
		.mismatch_count (mismatch_count),
		.units_due_count(units_due_count)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	always @(posedge clk) begin
		unit_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
	end

	initial begin
		#2_000_000;
		$display("FAIL");
		$finish;
	end

	task automatic send_byte(input logic [7:0] b, input logic eot);
		while ($urandom_range(99) < sender_idle_pct) begin
			byte_ch.valid <= 1'b0;
			@(posedge clk);
		end
		byte_ch.valid <= 1'b1;
		byte_ch.in_byte <= b;
		byte_ch.end_of_text <= eot;
		do @(posedge clk); while (!byte_ch.ready);
		bytes_sent++;
	endtask

	task automatic wait_for_units_drained();
		byte_ch.valid <= 1'b0;
		do @(posedge clk); while (units_due_count != 0);
	endtask

	function automatic logic [20:0] pick_code_point(input int len);
		logic [20:0] cp;
		case (len)
			1: cp = 21'($urandom_range('h7F));
			2: cp = 21'($urandom_range('h7FF, 'h80));
			3: begin
				cp = 21'($urandom_range('hFFFF, 'h800));
				if (cp >= SURR_LO && cp <= SURR_HI)
					cp = cp - 21'h1000;
			end
			default: cp = 21'($urandom_range(MAX_CP, SUPP_BASE));
		endcase
		return cp;
	endfunction

	// mostly well-formed characters, the rest overlong, surrogate, too large,
	// cut short or a lone random byte
	task automatic send_random_group();
		logic [20:0] cp;
		logic [31:0] seq;
		int          len;
		int          keep;
		int          kind;
		kind = $urandom_range(99);
		len = $urandom_range(4, 1);
		if (kind < 60) begin
			cp = pick_code_point(len);
		end else if (kind < 68) begin
			len = $urandom_range(4, 2);
			cp = (len == 2) ? 21'($urandom_range('h7F)) :
				(len == 3) ? 21'($urandom_range('h7FF)) : 21'($urandom_range('hFFFF));
		end else if (kind < 74) begin
			len = 3;
			cp = 21'($urandom_range('hDFFF, 'hD800));
		end else if (kind < 80) begin
			len = 4;
			cp = 21'($urandom_range('h1FFFFF, 'h110000));
		end else begin
			len = $urandom_range(4, 2);
			cp = pick_code_point(len);
		end
		case (len)
			1: seq = {24'd0, 1'b0, cp[6:0]};
			2: seq = {16'd0, 2'b10, cp[5:0], 3'b110, cp[10:6]};
			3: seq = {8'd0, 2'b10, cp[5:0], 2'b10, cp[11:6], 4'b1110, cp[15:12]};
			default: seq = {2'b10, cp[5:0], 2'b10, cp[11:6], 2'b10, cp[17:12],
				5'b11110, cp[20:18]};
		endcase
		keep = len;
		if (kind >= 90) begin
			seq[7:0] = 8'($urandom_range(255));
			keep = 1;
		end else if (kind >= 80) begin
			keep = $urandom_range(len - 1, 1);
		end
		for (int i = 0; i < keep; i++)
			send_byte(seq[8*i +: 8],
				(i == keep - 1 && $urandom_range(99) < 12) || $urandom_range(99) < 2);
	endtask

	initial begin
		byte_ch.valid = 1'b0;
		byte_ch.in_byte = 8'd0;
		byte_ch.end_of_text = 1'b0;
		unit_ch.ready = 1'b0;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_bytes[i])
			send_byte(directed_bytes[i][7:0], directed_bytes[i][8]);
		while (bytes_sent < 140)
			send_random_group();
		wait_for_units_drained();

		sender_idle_pct = 63;
		sink_stall_pct = 24;
		while (bytes_sent < 255)
			send_random_group();
		wait_for_units_drained();

		sender_idle_pct = 0;
		sink_stall_pct = 0;
		while (bytes_sent < 370)
			send_random_group();
		wait_for_units_drained();
		repeat (20) @(posedge clk);

		if (mismatch_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
